>>> hw/rtl/float_vector_dot_product_unit_macros.svh
// Assertion macros used by the dot product unit's top-level RTL file.
`ifndef FLOAT_VECTOR_DOT_PRODUCT_UNIT_MACROS_SVH
`define FLOAT_VECTOR_DOT_PRODUCT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define FVDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define FVDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fvdp_pkg.sv
// Types, constants and helper functions of the dot product unit.
package fvdp_pkg;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] POS_ZERO  = 64'h0;
  localparam logic        REG_ELEMENT_IS_DOUBLE = 1'b0;

  typedef struct packed {
    logic [63:0] a_bits;
    logic [63:0] b_bits;
    logic        operand_null;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sum_bits;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic operand_null;
    logic last_element;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] bits;
  } prod_t;

  function automatic logic [5:0] lzc53(input logic [52:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd53;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(52 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/fvdp_mul.sv
// Four-stage binary64 multiplier with binary32 widening and round-to-nearest-even.
module fvdp_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  fvdp_pkg::in_item_t in_item,
  input  logic               is_dbl,
  output fvdp_pkg::prod_t    prod
);
  import fvdp_pkg::*;

  typedef struct packed {
    logic               sign;
    logic signed [12:0] exp;
    logic [52:0]        man;
    logic               nan;
    logic               inf;
    logic               zero;
  } fop_t;

  // Value of a finite operand is man * 2^(exp - 52), man normalised to bit 52.
  function automatic fop_t unpack(input logic [63:0] x, input logic dbl);
    fop_t               o;
    logic [52:0]        m;
    logic signed [12:0] e;
    logic [5:0]         lz;
    logic [10:0]        ef;
    logic [51:0]        ff;
    logic [7:0]         es;
    logic [22:0]        fs;
    ef = x[62:52];
    ff = x[51:0];
    es = x[30:23];
    fs = x[22:0];
    o  = '0;
    if (dbl) begin
      o.sign = x[63];
      o.nan  = (ef == 11'h7FF) && (ff != '0);
      o.inf  = (ef == 11'h7FF) && (ff == '0);
      o.zero = (ef == '0) && (ff == '0);
      m      = {(ef != '0), ff};
      e      = (ef == '0) ? -13'sd1022 : $signed({2'b00, ef}) - 13'sd1023;
    end else begin
      o.sign = x[31];
      o.nan  = (es == 8'hFF) && (fs != '0);
      o.inf  = (es == 8'hFF) && (fs == '0);
      o.zero = (es == '0) && (fs == '0);
      m      = {(es != '0), fs, 29'd0};
      e      = (es == '0) ? -13'sd126 : $signed({5'b00000, es}) - 13'sd127;
    end
    lz    = lzc53(m);
    o.man = m << lz;
    o.exp = e - $signed({7'b0000000, lz});
    return o;
  endfunction

  // Stage 1: decoded operands.
  fop_t s1_a_r, s1_b_r;
  tag_t s1_tag_r;

  // Stage 2: partial products and combined exponent.
  logic [51:0]        s2_hh_r;
  logic [52:0]        s2_hl_r, s2_lh_r;
  logic [53:0]        s2_ll_r;
  logic               s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic signed [12:0] s2_exp_r;
  tag_t               s2_tag_r;

  // Stage 3: full 106-bit significand product.
  logic [105:0]       s3_p_r;
  logic               s3_sign_r, s3_nan_r, s3_inf_r, s3_zero_r;
  logic signed [12:0] s3_exp_r;
  tag_t               s3_tag_r;

  // Stage 4: rounded product.
  tag_t        prod_tag_r;
  logic [63:0] prod_bits_r;
  logic [63:0] rnd_bits;

  always_comb begin
    logic [105:0]       sig;
    logic signed [12:0] ex;
    logic signed [13:0] exw, dd;
    logic [6:0]         sh;
    logic [105:0]       q, rs, mask;
    logic               rb, st;
    logic [53:0]        rounded;
    logic [63:0]        base, res;
    sig  = s3_p_r[105] ? s3_p_r : {s3_p_r[104:0], 1'b0};
    ex   = s3_exp_r + (s3_p_r[105] ? 13'sd1 : 13'sd0);
    exw  = 14'(ex);
    dd   = -14'sd1022 - exw;
    if (dd > 14'sd57) begin
      sh = 7'd110;
    end else if (dd > 14'sd0) begin
      sh = 7'(14'sd53 + dd);
    end else begin
      sh = 7'd53;
    end
    q       = sig >> sh;
    rs      = sig >> (sh - 7'd1);
    rb      = rs[0];
    mask    = ~({106{1'b1}} << (sh - 7'd1));
    st      = |(sig & mask);
    rounded = {1'b0, q[52:0]} + {53'd0, rb & (st | q[0])};
    base    = (dd > 14'sd0) ? 64'd0 : {1'b0, 11'(ex + 13'sd1022), 52'd0};
    res     = base + {10'd0, rounded};
    if (s3_nan_r) begin
      rnd_bits = CANON_NAN;
    end else if (s3_inf_r || (ex > 13'sd1023) || (res[62:52] == 11'h7FF)) begin
      rnd_bits = {s3_sign_r, 11'h7FF, 52'd0};
    end else if (s3_zero_r) begin
      rnd_bits = {s3_sign_r, 63'd0};
    end else begin
      rnd_bits = {s3_sign_r, res[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r   <= '0;
      s2_tag_r   <= '0;
      s3_tag_r   <= '0;
      prod_tag_r <= '0;
    end else if (en) begin
      s1_tag_r   <= '{valid: in_vld, operand_null: in_item.operand_null,
                      last_element: in_item.last_element};
      s2_tag_r   <= s1_tag_r;
      s3_tag_r   <= s2_tag_r;
      prod_tag_r <= s3_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r    <= unpack(in_item.a_bits, is_dbl);
      s1_b_r    <= unpack(in_item.b_bits, is_dbl);
      s2_hh_r   <= s1_a_r.man[52:27] * s1_b_r.man[52:27];
      s2_hl_r   <= s1_a_r.man[52:27] * s1_b_r.man[26:0];
      s2_lh_r   <= s1_a_r.man[26:0] * s1_b_r.man[52:27];
      s2_ll_r   <= s1_a_r.man[26:0] * s1_b_r.man[26:0];
      s2_sign_r <= s1_a_r.sign ^ s1_b_r.sign;
      s2_exp_r  <= s1_a_r.exp + s1_b_r.exp;
      s2_nan_r  <= s1_a_r.nan || s1_b_r.nan || (s1_a_r.inf && s1_b_r.zero)
                   || (s1_a_r.zero && s1_b_r.inf);
      s2_inf_r  <= s1_a_r.inf || s1_b_r.inf;
      s2_zero_r <= s1_a_r.zero || s1_b_r.zero;
      s3_p_r    <= {s2_hh_r, 54'd0} + ({52'd0, {1'b0, s2_hl_r} + {1'b0, s2_lh_r}} << 27)
                   + {52'd0, s2_ll_r};
      s3_sign_r <= s2_sign_r;
      s3_exp_r  <= s2_exp_r;
      s3_nan_r  <= s2_nan_r;
      s3_inf_r  <= s2_inf_r && !s2_nan_r;
      s3_zero_r <= s2_zero_r && !s2_nan_r && !s2_inf_r;
      prod_bits_r <= rnd_bits;
    end
  end

  assign prod = '{tag: prod_tag_r, bits: prod_bits_r};

endmodule

>>> hw/rtl/fvdp_acc.sv
// Binary64 accumulator with a round-to-nearest-even adder.
module fvdp_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  fvdp_pkg::prod_t     prod,
  output logic                res_vld,
  output fvdp_pkg::out_item_t res
);
  import fvdp_pkg::*;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [63:0] bg, sm;
    logic [10:0] ex, ey, diff;
    logic [52:0] mx, my;
    logic [55:0] x, y0, y, n;
    logic [56:0] s57;
    logic [5:0]  lz;
    logic [10:0] sh;
    logic [11:0] e;
    logic [53:0] m;
    logic [64:0] rw;
    a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == '0);
    b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
    a_zero = (a[62:0] == '0);
    b_zero = (b[62:0] == '0);
    if (a_nan || b_nan || (a_inf && b_inf && (a[63] != b[63]))) begin
      return CANON_NAN;
    end
    if (a_inf) begin
      return a;
    end
    if (b_inf) begin
      return b;
    end
    if (a_zero && b_zero) begin
      return {a[63] & b[63], 63'd0};
    end
    bg   = (a[62:0] >= b[62:0]) ? a : b;
    sm   = (a[62:0] >= b[62:0]) ? b : a;
    ex   = (bg[62:52] == '0) ? 11'd1 : bg[62:52];
    ey   = (sm[62:52] == '0) ? 11'd1 : sm[62:52];
    mx   = {(bg[62:52] != '0), bg[51:0]};
    my   = {(sm[62:52] != '0), sm[51:0]};
    diff = ex - ey;
    x    = {mx, 3'b000};
    y0   = {my, 3'b000};
    if (diff >= 11'd56) begin
      y = {55'd0, |my};
    end else begin
      y = (y0 >> diff) | {55'd0, |(y0 & ~({56{1'b1}} << diff))};
    end
    s57 = (bg[63] == sm[63]) ? ({1'b0, x} + {1'b0, y}) : ({1'b0, x} - {1'b0, y});
    if (s57 == '0) begin
      return POS_ZERO;
    end
    if (s57[56]) begin
      n = s57[56:1] | {55'd0, s57[0]};
      e = {1'b0, ex} + 12'd1;
    end else begin
      lz = lzc56(s57[55:0]);
      sh = ({5'd0, lz} > (ex - 11'd1)) ? (ex - 11'd1) : {5'd0, lz};
      n  = s57[55:0] << sh;
      e  = {1'b0, ex - sh};
    end
    m  = {1'b0, n[55:3]} + {53'd0, n[2] & (n[1] | n[0] | n[3])};
    rw = {1'b0, e - 12'd1, 52'd0} + {11'd0, m};
    if (rw[64:52] >= 13'd2047) begin
      return {bg[63], 11'h7FF, 52'd0};
    end
    return {bg[63], rw[62:0]};
  endfunction

  logic [63:0] acc_r, acc_nxt;
  logic        null_r, null_nxt;
  logic [63:0] sum;
  logic        is_null;

  always_comb begin
    sum      = fadd(acc_r, prod.bits);
    is_null  = null_r || prod.tag.operand_null;
    acc_nxt  = acc_r;
    null_nxt = null_r;
    if (en && prod.tag.valid) begin
      if (prod.tag.last_element) begin
        acc_nxt  = POS_ZERO;
        null_nxt = 1'b0;
      end else begin
        acc_nxt  = sum;
        null_nxt = is_null;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= POS_ZERO;
      null_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      null_r <= null_nxt;
    end
  end

  assign res_vld      = prod.tag.valid && prod.tag.last_element;
  assign res.status   = is_null;
  assign res.sum_bits = is_null ? 64'd0 : sum;

endmodule

>>> hw/rtl/float_vector_dot_product_unit.sv
// Top level of the floating-point vector dot product unit.
//
// Element pairs arrive on the in_ channel (valid/ready), one transfer per
// pair, and the dot product leaves on the out_ channel when the pair marked
// last_element has been summed. The element type is set by register 0 on the
// APB-style port (1 = binary64, 0 = binary32 in the low 32 bits); it should
// be written only while no vector is in flight.
// Throughput is one pair per cycle while in_ready is high: the multiplier
// is a four-stage pipeline and only the binary64 accumulation closes a loop.
// The last pair passes the input register, the four multiplier stages and
// the accumulator adder before its sum is registered for out_valid.
// Reset clears the accumulator to +0.0, the null flag, the element type and
// all pipeline valid bits. If the receiver stalls, pairs keep flowing and
// accumulating; in_ready drops only when a finished sum reaches the
// accumulator while the previous result still waits in the output register.
module float_vector_dot_product_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fvdp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fvdp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fvdp_pkg::*;

`include "float_vector_dot_product_unit_macros.svh"

  logic      dbl_r;
  logic      s0_vld_r;
  in_item_t  s0_data_r;
  logic      s0_dbl_r;
  logic      out_vld_r;
  out_item_t out_data_r;
  prod_t     prod;
  logic      res_vld;
  out_item_t res;
  logic      en;

  // Configuration register; the index is the address divided by four.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ELEMENT_IS_DOUBLE) ? {31'd0, dbl_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_ELEMENT_IS_DOUBLE)) begin
      dbl_r <= pwdata[0];
    end
  end

  // The whole pipeline advances together unless a finished sum would
  // overwrite a result that the receiver has not yet taken.
  assign en       = !(out_vld_r && !out_ready && res_vld);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  // The element type travels with each pair, taken at its transfer.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_data_r <= in_data;
      s0_dbl_r  <= dbl_r;
    end
  end

  fvdp_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s0_vld_r),
    .in_item (s0_data_r),
    .is_dbl  (s0_dbl_r),
    .prod    (prod)
  );

  fvdp_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .prod    (prod),
    .res_vld (res_vld),
    .res     (res)
  );

  // Output register; a NaN sum leaves as the canonical quiet NaN.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res_vld) begin
      out_data_r.status <= res.status;
      if ((res.sum_bits[62:52] == 11'h7FF) && (res.sum_bits[51:0] != '0)) begin
        out_data_r.sum_bits <= CANON_NAN;
      end else begin
        out_data_r.sum_bits <= res.sum_bits;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `FVDP_ASSERT_NXT(a_result_loads, res_vld && in_ready, out_vld_r,
    "finished sum was not captured in the output register")
  `FVDP_ASSERT_IMP(a_null_zero, out_vld_r && out_data_r.status,
    out_data_r.sum_bits == 64'd0, "null result carries a non-zero sum")
  `FVDP_ASSERT_IMP(a_nan_canon,
    out_vld_r && (out_data_r.sum_bits[62:52] == 11'h7FF) && (out_data_r.sum_bits[51:0] != '0),
    out_data_r.sum_bits == CANON_NAN, "NaN result is not the canonical quiet NaN")

endmodule
